// ===== rtl/rhh_pkg.sv =====
// Shared types and constants for the Robin Hood hash intern table.
// Used by every module in rtl/; depends on nothing.
package rhh_pkg;

  localparam int unsigned HASH_W   = 32;
  localparam int unsigned HANDLE_W = 10;
  localparam int unsigned SIZE_W   = 4;
  localparam int unsigned SIZE_MIN = 4;
  localparam int unsigned SIZE_MAX = 10;
  localparam int unsigned LOAD_PCT = 90;
  localparam int unsigned PCT_BASE = 100;

  typedef enum logic {
    CMD_FIND   = 1'b0,
    CMD_UPSERT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [31:0]       key_hash;
    logic [63:0]       key_value;
  } in_req_t;

  typedef struct packed {
    status_t              status;
    logic [HANDLE_W-1:0]  handle;
  } out_rsp_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_PROBE,
    FSM_PCHECK,
    FSM_PLACE,
    FSM_PWAIT,
    FSM_RESP
  } fsm_t;

  // Per-probe control from the sequencer to the slot store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== rtl/robin_hood_hash_intern_table.sv =====
// Robin Hood linear-probe intern table.
// Request channel (in_valid/in_stall, in_req) carries cmd, key_hash and
// key_value. Result channel (out_valid/out_stall, out_rsp) returns status
// and handle, one result per request, in request order.
// cfg_we/cfg_wdata write size_log2 (saturated to 4..10 and to the depth).
// Operation: one request at a time. Each probed slot passes through the
// PROBE and PCHECK states because the next address waits for the slot
// RAM's registered read. An upsert that misses in its probe then walks the
// slots from home to place the new entry, through PWAIT and PLACE for each
// slot. The next request is taken in the cycle the result appears, unless
// out_stall holds the result.
// Reset (synchronous, rst_n low) zeroes the entry count and handle
// allocator and sets size_log2 to 10; a clearing pass then empties one slot
// per cycle, holding in_stall high until every slot is empty.
// While a result waits with out_stall high it holds steady and in_stall
// stays high.
module robin_hood_hash_intern_table #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rhh_pkg::in_req_t              in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rhh_pkg::out_rsp_t             out_rsp,
  input  logic                          cfg_we,
  input  logic [rhh_pkg::SIZE_W-1:0]    cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  // Log2 of the largest power of two not above the depth.
  localparam int unsigned DEPTH_LOG = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int unsigned HW = rhh_pkg::HASH_W;
  localparam int unsigned LW = rhh_pkg::HANDLE_W;
  localparam int unsigned DATA_W = ADDR_W + HW + KEY_BITS + LW;
  localparam int unsigned CNT_W = ADDR_W + 1;

  rhh_pkg::fsm_t state_r, state_nxt;

  logic [rhh_pkg::SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]    step_r, step_nxt;
  logic [ADDR_W-1:0]   cd_r, cd_nxt;
  logic [HW-1:0]       ch_r, ch_nxt;
  logic [KEY_BITS-1:0] ck_r, ck_nxt;
  logic [LW-1:0]       hd_r, hd_nxt;
  rhh_pkg::cmd_t       cmd_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LW-1:0]       nh_r, nh_nxt;
  rhh_pkg::out_rsp_t   rsp_r, rsp_nxt;
  logic                ov_r, ov_nxt;

  rhh_pkg::mem_ctl_t   ctl;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DATA_W-1:0]   wr_data, rd_data;
  logic                rd_valid;
  logic                clearing;

  // Active size, mask and full threshold from the size register.
  logic [3:0]          eff_log;
  logic [CNT_W-1:0]    n_size;
  logic [ADDR_W-1:0]   mask;
  logic [CNT_W-1:0]    full_lim;

  always_comb begin
    eff_log = size_r;
    if (eff_log < 4'(rhh_pkg::SIZE_MIN)) eff_log = 4'(rhh_pkg::SIZE_MIN);
    if (eff_log > 4'(rhh_pkg::SIZE_MAX)) eff_log = 4'(rhh_pkg::SIZE_MAX);
    if (32'(eff_log) > DEPTH_LOG) eff_log = 4'(DEPTH_LOG);
    n_size = CNT_W'(1) << eff_log;
    mask   = ADDR_W'(n_size - CNT_W'(1));
  end

  // Full limit 90*n/100 for each active size, folded to constants.
  always_comb begin
    unique case (eff_log)
      4'd4:    full_lim = CNT_W'((rhh_pkg::LOAD_PCT << 4) / rhh_pkg::PCT_BASE);
      4'd5:    full_lim = CNT_W'((rhh_pkg::LOAD_PCT << 5) / rhh_pkg::PCT_BASE);
      4'd6:    full_lim = CNT_W'((rhh_pkg::LOAD_PCT << 6) / rhh_pkg::PCT_BASE);
      4'd7:    full_lim = CNT_W'((rhh_pkg::LOAD_PCT << 7) / rhh_pkg::PCT_BASE);
      4'd8:    full_lim = CNT_W'((rhh_pkg::LOAD_PCT << 8) / rhh_pkg::PCT_BASE);
      4'd9:    full_lim = CNT_W'((rhh_pkg::LOAD_PCT << 9) / rhh_pkg::PCT_BASE);
      default: full_lim = CNT_W'((rhh_pkg::LOAD_PCT << 10) / rhh_pkg::PCT_BASE);
    endcase
  end

  // Unpack the slot read.
  logic [ADDR_W-1:0]   s_dist;
  logic [HW-1:0]       s_hash;
  logic [KEY_BITS-1:0] s_key;
  logic [LW-1:0]       s_hd;
  assign {s_dist, s_hash, s_key, s_hd} = rd_data;

  logic [KEY_BITS-1:0] in_key;
  assign in_key = in_req.key_value[KEY_BITS-1:0];

  logic accept, out_take;
  assign accept   = in_valid && !in_stall;
  assign out_take = ov_r && !out_stall;
  assign in_stall = clearing || (state_r != rhh_pkg::FSM_IDLE) || (ov_r && out_stall);

  logic step_last;
  assign step_last = (step_r + CNT_W'(1)) >= n_size;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rhh_pkg::FSM_IDLE:   if (accept) state_nxt = rhh_pkg::FSM_PROBE;
      rhh_pkg::FSM_PROBE: begin
        if (!rd_valid || (ADDR_W'(step_r) > s_dist) ||
            (s_hash == ch_r && s_key == ck_r) || step_last) begin
          if (rd_valid && ADDR_W'(step_r) <= s_dist &&
              s_hash == ch_r && s_key == ck_r) begin
            state_nxt = rhh_pkg::FSM_RESP;
          end else if (cmd_r == rhh_pkg::CMD_UPSERT && cnt_r < full_lim) begin
            state_nxt = rhh_pkg::FSM_PWAIT;
          end else begin
            state_nxt = rhh_pkg::FSM_RESP;
          end
        end else begin
          state_nxt = rhh_pkg::FSM_PCHECK;
        end
      end
      rhh_pkg::FSM_PCHECK: state_nxt = rhh_pkg::FSM_PROBE;
      rhh_pkg::FSM_PWAIT:  state_nxt = rhh_pkg::FSM_PLACE;
      rhh_pkg::FSM_PLACE: begin
        if (!rd_valid || step_last) state_nxt = rhh_pkg::FSM_RESP;
        else state_nxt = rhh_pkg::FSM_PWAIT;
      end
      rhh_pkg::FSM_RESP:   state_nxt = rhh_pkg::FSM_IDLE;
      default:             state_nxt = rhh_pkg::FSM_IDLE;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    idx_nxt  = idx_r;
    step_nxt = step_r;
    cd_nxt   = cd_r;
    ch_nxt   = ch_r;
    ck_nxt   = ck_r;
    hd_nxt   = hd_r;
    cnt_nxt  = cnt_r;
    nh_nxt   = nh_r;
    rsp_nxt  = rsp_r;
    ov_nxt   = ov_r && !out_take;
    ctl      = '0;
    wr_addr  = idx_r;
    wr_data  = {cd_r, ch_r, ck_r, hd_r};
    unique case (state_r)
      rhh_pkg::FSM_IDLE: begin
        if (accept) begin
          idx_nxt  = in_req.key_hash[ADDR_W-1:0] & mask;
          step_nxt = '0;
          cd_nxt   = '0;
          ch_nxt   = in_req.key_hash;
          ck_nxt   = in_key;
          ctl.rd_en = 1'b1;
        end
      end
      rhh_pkg::FSM_PROBE: begin
        if (rd_valid && ADDR_W'(step_r) <= s_dist &&
            s_hash == ch_r && s_key == ck_r) begin
          rsp_nxt.status = rhh_pkg::ST_FOUND;
          rsp_nxt.handle = s_hd;
        end else if (!rd_valid || ADDR_W'(step_r) > s_dist || step_last) begin
          if (cmd_r == rhh_pkg::CMD_UPSERT && cnt_r < full_lim) begin
            // Restart from home to place the new entry.
            idx_nxt  = ch_r[ADDR_W-1:0] & mask;
            step_nxt = '0;
            cd_nxt   = '0;
            hd_nxt   = nh_r;
            rsp_nxt.status = rhh_pkg::ST_INSERTED;
            rsp_nxt.handle = nh_r;
            nh_nxt   = nh_r + LW'(1);
            ctl.rd_en = 1'b1;
            idx_nxt  = ch_r[ADDR_W-1:0] & mask;
          end else begin
            rsp_nxt.status = (cmd_r == rhh_pkg::CMD_UPSERT) ? rhh_pkg::ST_FULL
                                                              : rhh_pkg::ST_NOT_FOUND;
            rsp_nxt.handle = '0;
          end
        end else begin
          idx_nxt  = (idx_r + ADDR_W'(1)) & mask;
          step_nxt = step_r + CNT_W'(1);
        end
      end
      rhh_pkg::FSM_PCHECK: begin
        ctl.rd_en = 1'b1;
      end
      rhh_pkg::FSM_PWAIT: begin
      end
      rhh_pkg::FSM_PLACE: begin
        if (!rd_valid) begin
          ctl.wr_en = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          if (s_dist < cd_r) begin
            ctl.wr_en = 1'b1;
            cd_nxt = s_dist + ADDR_W'(1);
            ch_nxt = s_hash;
            ck_nxt = s_key;
            hd_nxt = s_hd;
          end else begin
            cd_nxt = cd_r + ADDR_W'(1);
          end
          idx_nxt  = (idx_r + ADDR_W'(1)) & mask;
          step_nxt = step_r + CNT_W'(1);
          ctl.rd_en = !step_last;
        end
      end
      rhh_pkg::FSM_RESP: begin
        ov_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The read address is the index register's next value.
  logic [ADDR_W-1:0] rd_addr;
  assign rd_addr = idx_nxt;

  rhh_slot_mem #(
    .DEPTH  (TABLE_DEPTH),
    .KEY_W  (KEY_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clearing (clearing),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhh_pkg::FSM_IDLE;
      size_r  <= 4'(rhh_pkg::SIZE_MAX);
      cnt_r   <= '0;
      nh_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nh_r    <= nh_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) size_r <= cfg_wdata;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    step_r <= step_nxt;
    cd_r   <= cd_nxt;
    ch_r   <= ch_nxt;
    ck_r   <= ck_nxt;
    hd_r   <= hd_nxt;
    rsp_r  <= rsp_nxt;
    if (accept) cmd_r <= in_req.cmd;
  end

  assign out_valid = ov_r;
  assign out_rsp   = rsp_r;

endmodule

// ===== rtl/rhh_slot_mem.sv =====
// Slot store of the intern table: one synchronous RAM whose words hold a valid
// bit, distance, hash, key and handle, emptied by a clearing pass after reset.
// Uses rhh_pkg.
module rhh_slot_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned KEY_W  = 64,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rhh_pkg::mem_ctl_t           ctl,
  input  logic [ADDR_W-1:0]           rd_addr,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [ADDR_W+rhh_pkg::HASH_W+KEY_W+rhh_pkg::HANDLE_W-1:0] wr_data,
  output logic                        clearing,
  output logic                        rd_valid,
  output logic [ADDR_W+rhh_pkg::HASH_W+KEY_W+rhh_pkg::HANDLE_W-1:0] rd_data
);

  localparam int unsigned DATA_W = ADDR_W + rhh_pkg::HASH_W + KEY_W + rhh_pkg::HANDLE_W;

  // Each word carries its valid bit above the slot payload.
  logic [DATA_W:0]   mem [DEPTH];
  logic [DATA_W:0]   rd_word_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              clr_busy_r;

  // After reset the pass writes one empty word per cycle, through address DEPTH-1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  // Slot RAM: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= {1'b1, wr_data};
    end
    if (ctl.rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  assign clearing = clr_busy_r;
  assign rd_valid = rd_word_r[DATA_W];
  assign rd_data  = rd_word_r[DATA_W-1:0];

endmodule

// ===== rtl/rhh_checker.sv =====
// Port-level checks for the intern table, bound to the top level.
// Depends on rhh_pkg and robin_hood_hash_intern_table.
module rhh_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input rhh_pkg::out_rsp_t out_rsp
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  // Not found and full carry a zero handle.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == rhh_pkg::ST_NOT_FOUND ||
                  out_rsp.status == rhh_pkg::ST_FULL) |-> out_rsp.handle == '0)
    else $error("nonzero handle on miss");

  // A request accepted cannot produce a result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind robin_hood_hash_intern_table rhh_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
);
